[src/fixed_timestep_scheduler_defines.svh]
// Assertion macros shared by the scheduler modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef FIXED_TIMESTEP_SCHEDULER_DEFINES_SVH
`define FIXED_TIMESTEP_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define FTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fixed_timestep_scheduler: check failed");

// Next-cycle implication, disabled in reset
`define FTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fixed_timestep_scheduler: check failed");

`else

`define FTS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FTS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

[src/fts_pkg.sv]
package fts_pkg;

    // Fixed widths of the configuration registers
    localparam int STEP_W  = 24;
    localparam int FRAME_W = 32;
    localparam int COUNT_W = 6;

    // APB map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_STEP_LENGTH = 2'd0;
    localparam logic [1:0] REG_MAX_FRAME   = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS   = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd16667;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 32'd250000;
    localparam logic [COUNT_W-1:0] STEPS_RESET = 6'd5;

    // Input mode and result kind codes
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_CLEAR   = 1'b1;
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic tick;
        logic div_load_mod;
        logic div_step;
        logic finish_mod;
        logic div_load_alpha;
        logic emit_sum;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_flag;
        logic zero_delta;
        logic can_tick;
        logic div_done;
    } status_t;

endpackage

[src/fts_ctrl.sv]
`include "fixed_timestep_scheduler_defines.svh"

module fts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  fts_pkg::status_t status,
    output fts_pkg::cmd_t    cmd
);
    import fts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TICK_OUT,
        S_MOD,
        S_ALPHA_LOAD,
        S_ALPHA,
        S_SUM_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // Sequence ticks, backlog modulo, alpha division, summary, or clear
    always_comb begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load      = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.clear_flag) begin
                    in_ready_next = 1'b1;
                    state_next    = S_IDLE;
                end else if (status.zero_delta) begin
                    state_next = S_ALPHA_LOAD;
                end else if (status.can_tick) begin
                    cmd.tick       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_TICK_OUT;
                end else begin
                    cmd.div_load_mod = 1'b1;
                    state_next       = S_MOD;
                end
            end
            S_TICK_OUT: begin
                if (out_ready) begin
                    out_valid_next = 1'b0;
                    state_next     = S_CHECK;
                end
            end
            S_MOD: begin
                if (status.div_done) begin
                    cmd.finish_mod = 1'b1;
                    state_next     = S_ALPHA_LOAD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_ALPHA_LOAD: begin
                cmd.div_load_alpha = 1'b1;
                state_next         = S_ALPHA;
            end
            S_ALPHA: begin
                if (status.div_done) begin
                    cmd.emit_sum   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_SUM_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SUM_OUT: begin
                if (out_ready) begin
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                out_valid_next = 1'b0;
                in_ready_next  = 1'b1;
                state_next     = S_IDLE;
            end
        endcase
    end

    // Hold state and handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FTS_ASSERT_IMP(a_ready_valid_excl, aclk, aresetn, in_ready_reg, !out_valid_reg)
    `FTS_ASSERT_IMP(a_tick_gated, aclk, aresetn, cmd.tick, status.can_tick)
    `FTS_ASSERT_IMP(a_div_step_live, aclk, aresetn, cmd.div_step, !status.div_done)

endmodule

[src/fts_dp.sv]
`include "fixed_timestep_scheduler_defines.svh"

module fts_dp #(
    parameter int TIME_WIDTH     = 32,
    parameter int SIM_TIME_WIDTH = 48,
    parameter int ALPHA_BITS     = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [fts_pkg::STEP_W-1:0]         step,
    input  logic [fts_pkg::FRAME_W-1:0]        max_frame,
    input  logic [fts_pkg::COUNT_W-1:0]        limit,
    input  logic                               in_mode,
    input  logic [TIME_WIDTH-1:0]              in_delta,
    input  fts_pkg::cmd_t                      cmd,
    output fts_pkg::status_t                   status,
    output logic                               out_kind,
    output logic [SIM_TIME_WIDTH-1:0]          out_sim_time,
    output logic [fts_pkg::COUNT_W-1:0]        out_step_count,
    output logic [TIME_WIDTH-1:0]              out_accepted,
    output logic [TIME_WIDTH-1:0]              out_dropped,
    output logic [ALPHA_BITS-1:0]              out_alpha,
    output logic                               out_last
);
    import fts_pkg::*;

    localparam int SUM_W = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;
    localparam int CMP_W = (TIME_WIDTH > FRAME_W) ? TIME_WIDTH : FRAME_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

    // Architectural state
    logic [STEP_W-1:0]         accum_reg;
    logic [SIM_TIME_WIDTH-1:0] sim_reg;
    // Per-frame working registers
    logic [SUM_W-1:0]          acc_reg;
    logic [TIME_WIDTH-1:0]     accepted_reg;
    logic [TIME_WIDTH-1:0]     dropped_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic                      clear_reg;
    logic                      zero_reg;
    // Shared restoring divider
    logic [STEP_W-1:0]         rem_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [CNT_W-1:0]          div_cnt_reg;
    logic                      sat_reg;

    logic [CMP_W-1:0]          frame_max_w;
    logic [TIME_WIDTH-1:0]     accepted_w;
    logic [STEP_W:0]           rem_shift;
    logic [STEP_W:0]           rem_sub;
    logic                      rem_ge;
    logic [SUM_W-1:0]          backlog;
    logic [SUM_W:0]            drop_sum;
    logic [TIME_WIDTH-1:0]     drop_sat;
    logic [SIM_TIME_WIDTH-1:0] sim_tick;

    // Clamp the frame to max(max_frame, step)
    always_comb begin
        frame_max_w = (CMP_W'(max_frame) < CMP_W'(step)) ? CMP_W'(step) : CMP_W'(max_frame);
        accepted_w  = (CMP_W'(in_delta) < frame_max_w) ? in_delta
                                                       : frame_max_w[TIME_WIDTH-1:0];
    end

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, step};
    assign rem_sub   = rem_shift - {1'b0, step};

    // Drop the whole-step backlog and saturate the dropped time
    assign backlog  = acc_reg - SUM_W'(rem_reg);
    assign drop_sum = (SUM_W + 1)'(dropped_reg) + (SUM_W + 1)'(backlog);
    assign drop_sat = (|drop_sum[SUM_W:TIME_WIDTH]) ? '1 : drop_sum[TIME_WIDTH-1:0];

    assign sim_tick = sim_reg + SIM_TIME_WIDTH'(step);

    assign status.clear_flag = clear_reg;
    assign status.zero_delta = zero_reg;
    assign status.can_tick   = (acc_reg >= SUM_W'(step)) && (n_reg < limit);
    assign status.div_done   = (div_cnt_reg == '0);

    // Accumulator, simulation time and divider count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg   <= '0;
            sim_reg     <= '0;
            div_cnt_reg <= '0;
            clear_reg   <= 1'b0;
            zero_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                clear_reg <= (in_mode == MODE_CLEAR);
                zero_reg  <= (in_delta == '0);
                if (in_mode == MODE_CLEAR) begin
                    accum_reg <= '0;
                    sim_reg   <= '0;
                end
            end
            if (cmd.tick) begin
                sim_reg <= sim_tick;
            end
            if (cmd.finish_mod) begin
                accum_reg <= rem_reg;
            end
            if (cmd.div_load_mod) begin
                div_cnt_reg <= CNT_W'(SUM_W);
            end else if (cmd.div_load_alpha) begin
                div_cnt_reg <= CNT_W'(ALPHA_BITS);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    // Frame working values and divider data
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg      <= SUM_W'(accum_reg) + SUM_W'(accepted_w);
            accepted_reg <= accepted_w;
            dropped_reg  <= in_delta - accepted_w;
            n_reg        <= '0;
        end
        if (cmd.tick) begin
            acc_reg <= acc_reg - SUM_W'(step);
            n_reg   <= n_reg + 1'b1;
        end
        if (cmd.finish_mod) begin
            acc_reg     <= SUM_W'(rem_reg);
            dropped_reg <= drop_sat;
        end
        if (cmd.div_load_mod) begin
            rem_reg <= '0;
            quo_reg <= acc_reg;
        end else if (cmd.div_load_alpha) begin
            rem_reg <= accum_reg;
            quo_reg <= '0;
            sat_reg <= accum_reg >= step;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[STEP_W-1:0] : rem_shift[STEP_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
        end
    end

    // Output register: load a tick or the summary beat
    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            out_kind       <= KIND_TICK;
            out_sim_time   <= sim_tick;
            out_step_count <= n_reg + 1'b1;
            out_accepted   <= '0;
            out_dropped    <= '0;
            out_alpha      <= '0;
            out_last       <= 1'b0;
        end else if (cmd.emit_sum) begin
            out_kind       <= KIND_SUMMARY;
            out_sim_time   <= sim_reg;
            out_step_count <= n_reg;
            out_accepted   <= accepted_reg;
            out_dropped    <= dropped_reg;
            out_alpha      <= sat_reg ? '1 : quo_reg[ALPHA_BITS-1:0];
            out_last       <= 1'b1;
        end
    end

    `FTS_ASSERT_NXT(a_tick_count, aclk, aresetn, cmd.tick, n_reg == COUNT_W'($past(n_reg) + 1'b1))
    `FTS_ASSERT_NXT(a_mod_leftover, aclk, aresetn, cmd.finish_mod, accum_reg < step)
    `FTS_ASSERT_NXT(a_clear_zeroes, aclk, aresetn, cmd.load && in_mode == MODE_CLEAR, sim_reg == '0 && accum_reg == '0)

endmodule

[src/fixed_timestep_scheduler.sv]
// Order: an accepted frame enters the check state, which raises each tick beat; after
// a tick is taken the block returns to the check state for the next. The summary follows
// the last tick once the shared divider, one quotient bit per cycle, has run the backlog
// modulo and then the alpha division. A new frame is accepted only once the last frame's
// summary is taken or its clear is done; a zero delta skips the ticks and the modulo.
// Reset (aresetn low, synchronous): registers to defaults, accumulator and time to zero.
module fixed_timestep_scheduler #(
    parameter int TIME_WIDTH     = 32,
    parameter int SIM_TIME_WIDTH = 48,
    parameter int ALPHA_BITS     = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // frame input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((TIME_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // frame_delta
    input  logic                                  s_tuser,  // mode
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sim_time, step_count, accepted_time, dropped_time, alpha (low bit first)
    output logic [((SIM_TIME_WIDTH + fts_pkg::COUNT_W + 2 * TIME_WIDTH + ALPHA_BITS + 7)
                   / 8) * 8 - 1:0]                 m_tdata,
    output logic                                  m_tuser,  // kind
    output logic                                  m_tlast,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fts_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [fts_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [fts_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import fts_pkg::*;

    localparam int OUT_W      = SIM_TIME_WIDTH + COUNT_W + 2 * TIME_WIDTH + ALPHA_BITS;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    logic [STEP_W-1:0]  step_length_reg;
    logic [FRAME_W-1:0] max_frame_reg;
    logic [COUNT_W-1:0] max_steps_reg;
    logic [STEP_W-1:0]  step_eff;
    logic [COUNT_W-1:0] limit_eff;
    logic               cfg_write;

    cmd_t    cmd;
    status_t status;

    logic                      out_kind;
    logic [SIM_TIME_WIDTH-1:0] out_sim_time;
    logic [COUNT_W-1:0]        out_step_count;
    logic [TIME_WIDTH-1:0]     out_accepted;
    logic [TIME_WIDTH-1:0]     out_dropped;
    logic [ALPHA_BITS-1:0]     out_alpha;
    logic                      out_last;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg <= STEP_RESET;
            max_frame_reg   <= FRAME_RESET;
            max_steps_reg   <= STEPS_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_STEP_LENGTH: step_length_reg <= pwdata[STEP_W-1:0];
                REG_MAX_FRAME:   max_frame_reg   <= pwdata[FRAME_W-1:0];
                REG_MAX_STEPS:   max_steps_reg   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STEP_LENGTH: prdata = APB_DATA_W'(step_length_reg);
            REG_MAX_FRAME:   prdata = APB_DATA_W'(max_frame_reg);
            REG_MAX_STEPS:   prdata = APB_DATA_W'(max_steps_reg);
            default:         prdata = '0;
        endcase
    end

    // Treat a zero step or zero step limit as one
    assign step_eff  = (step_length_reg == '0) ? STEP_W'(1) : step_length_reg;
    assign limit_eff = (max_steps_reg == '0) ? COUNT_W'(1) : max_steps_reg;

    fts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    fts_dp #(
        .TIME_WIDTH     (TIME_WIDTH),
        .SIM_TIME_WIDTH (SIM_TIME_WIDTH),
        .ALPHA_BITS     (ALPHA_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step_eff),
        .max_frame      (max_frame_reg),
        .limit          (limit_eff),
        .in_mode        (s_tuser),
        .in_delta       (s_tdata[TIME_WIDTH-1:0]),
        .cmd            (cmd),
        .status         (status),
        .out_kind       (out_kind),
        .out_sim_time   (out_sim_time),
        .out_step_count (out_step_count),
        .out_accepted   (out_accepted),
        .out_dropped    (out_dropped),
        .out_alpha      (out_alpha),
        .out_last       (out_last)
    );

    // Pack the result beat
    assign m_tdata = OUT_DATA_W'({out_alpha, out_dropped, out_accepted,
                                  out_step_count, out_sim_time});
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

[tb/tb_fixed_timestep_scheduler.sv]
module tb_fixed_timestep_scheduler;
    import fts_pkg::*;

    localparam int TIME_W   = 32;
    localparam int SIM_W    = 48;
    localparam int ALPHA_W  = 16;
    localparam int S_DATA_W = ((TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SIM_W + COUNT_W + 2 * TIME_W + ALPHA_W + 7) / 8) * 8;

    // Result beat layout inside m_tdata, low bit first
    localparam int CNT_LSB   = SIM_W;
    localparam int ACC_LSB   = CNT_LSB + COUNT_W;
    localparam int DROP_LSB  = ACC_LSB + TIME_W;
    localparam int ALPHA_LSB = DROP_LSB + TIME_W;

    // Unmapped register slot, writes to it must be dropped
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 75;
    localparam longint TIMEOUT_TU = 64'd30_000_000;

    typedef struct {
        logic               kind;
        logic [SIM_W-1:0]   sim_time;
        logic [COUNT_W-1:0] step_count;
        logic [TIME_W-1:0]  accepted;
        logic [TIME_W-1:0]  dropped;
        logic [ALPHA_W-1:0] alpha;
        logic               last;
    } sched_beat_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_PERIODIC} rx_style_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // frame_delta
    logic                  s_tuser = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // sim_time, step_count, accepted_time, dropped_time, alpha (low bit first)
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;        // kind
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Scheduler mirror: configuration and running state
    logic [STEP_W-1:0]  step_reg  = STEP_RESET;
    logic [FRAME_W-1:0] frame_reg = FRAME_RESET;
    logic [COUNT_W-1:0] steps_reg = STEPS_RESET;
    logic [STEP_W-1:0]  acc_state = '0;
    logic [SIM_W-1:0]   sim_state = '0;

    sched_beat_t expected_beats[$];
    int          mismatches = 0;

    rx_style_t   rx_style = RX_OPEN;
    logic [15:0] rx_count = '0;

    fixed_timestep_scheduler #(
        .TIME_WIDTH     (TIME_W),
        .SIM_TIME_WIDTH (SIM_W),
        .ALPHA_BITS     (ALPHA_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_TU);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver backpressure: switch to a random style whenever the low byte of rx_count wraps
    always @(posedge aclk) begin
        rx_count <= rx_count + 16'd1;
        if (rx_count[7:0] == 8'd0)
            rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_tready <= ($urandom_range(0, 1) == 1);
            default:  m_tready <= (rx_count[1:0] == 2'b11);
        endcase
    end

    function automatic logic [ALPHA_W-1:0] alpha_q16(input logic [63:0] acc,
                                                     input logic [63:0] step);
        if (acc >= step)
            return '1;
        return ALPHA_W'((acc << ALPHA_W) / step);
    endfunction

    function automatic sched_beat_t make_beat(input logic kind, input logic [SIM_W-1:0] t,
                                              input logic [63:0] cnt, input logic [63:0] acc,
                                              input logic [63:0] drop,
                                              input logic [ALPHA_W-1:0] alpha,
                                              input logic last);
        sched_beat_t b;
        b.kind       = kind;
        b.sim_time   = t;
        b.step_count = cnt[COUNT_W-1:0];
        b.accepted   = acc[TIME_W-1:0];
        b.dropped    = drop[TIME_W-1:0];
        b.alpha      = alpha;
        b.last       = last;
        return b;
    endfunction

    // Advance the mirror by one frame and queue the beats it must produce
    function automatic void schedule_frame(input logic mode, input logic [TIME_W-1:0] delta);
        logic [63:0] step;
        logic [63:0] limit;
        logic [63:0] frame_max;
        logic [63:0] accepted;
        logic [63:0] dropped;
        logic [63:0] sum;
        logic [63:0] n;
        step  = (step_reg == '0) ? 64'd1 : 64'(step_reg);
        limit = (steps_reg == '0) ? 64'd1 : 64'(steps_reg);
        if (mode == MODE_CLEAR) begin
            acc_state = '0;
            sim_state = '0;
            return;
        end
        if (delta == '0) begin
            expected_beats.push_back(make_beat(KIND_SUMMARY, sim_state, 0, 0, 0,
                                               alpha_q16(64'(acc_state), step), 1'b1));
            return;
        end
        frame_max = (64'(frame_reg) < step) ? step : 64'(frame_reg);
        accepted  = (64'(delta) < frame_max) ? 64'(delta) : frame_max;
        dropped   = 64'(delta) - accepted;
        sum       = 64'(acc_state) + accepted;
        n         = 0;
        // Emit ticks while a whole step is available and the step limit is not reached
        while (sum >= step && n < limit) begin
            sum       = sum - step;
            sim_state = sim_state + step[SIM_W-1:0];
            n         = n + 1;
            expected_beats.push_back(make_beat(KIND_TICK, sim_state, n, 0, 0, '0, 1'b0));
        end
        // Drop the whole-step backlog, keep the remainder
        if (sum >= step) begin
            dropped = dropped + (sum - (sum % step));
            sum     = sum % step;
        end
        if (dropped > 64'hFFFF_FFFF)
            dropped = 64'hFFFF_FFFF;
        acc_state = sum[STEP_W-1:0];
        expected_beats.push_back(make_beat(KIND_SUMMARY, sim_state, n, accepted, dropped,
                                           alpha_q16(64'(acc_state), step), 1'b1));
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        sched_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("sim_time", want.sim_time, m_tdata[SIM_W-1:0]);
                check_field("step_count", want.step_count, m_tdata[CNT_LSB +: COUNT_W]);
                check_field("accepted_time", want.accepted, m_tdata[ACC_LSB +: TIME_W]);
                check_field("dropped_time", want.dropped, m_tdata[DROP_LSB +: TIME_W]);
                check_field("alpha", want.alpha, m_tdata[ALPHA_LSB +: ALPHA_W]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Offer one frame beat and hold it until accepted
    task automatic push_frame(input logic mode, input logic [TIME_W-1:0] delta);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= delta;
        do @(posedge aclk); while (!s_tready);
        schedule_frame(mode, delta);
    endtask

    task automatic hold_off(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop sending until every expected beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_beats.size() != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[3:2])
            REG_STEP_LENGTH: step_reg  = data[STEP_W-1:0];
            REG_MAX_FRAME:   frame_reg = data[FRAME_W-1:0];
            REG_MAX_STEPS:   steps_reg = data[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Reprogram all three registers once the block is idle
    task automatic set_timing(input logic [31:0] step, input logic [31:0] frame,
                              input logic [31:0] steps);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write({REG_STEP_LENGTH, 2'b00}, step);
        apb_write({REG_MAX_FRAME, 2'b00}, frame);
        apb_write({REG_MAX_STEPS, 2'b00}, steps);
    endtask

    // Random frame, biased toward deltas that produce several ticks
    task automatic pick_frame(output logic mode, output logic [TIME_W-1:0] delta);
        int unsigned sel;
        logic [63:0] step;
        logic [63:0] limit;
        logic [63:0] fmax;
        logic [63:0] span;
        step  = (step_reg == '0) ? 64'd1 : 64'(step_reg);
        limit = (steps_reg == '0) ? 64'd1 : 64'(steps_reg);
        fmax  = (64'(frame_reg) < step) ? step : 64'(frame_reg);
        span  = step * (limit + 1) + step / 2;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        sel  = $urandom_range(0, 99);
        mode = MODE_ADVANCE;
        if (sel < 4) begin
            mode  = MODE_CLEAR;
            delta = $urandom;
        end else if (sel < 10) begin
            delta = '0;
        end else if (sel < 20) begin
            delta = $urandom;
        end else if (sel < 30) begin
            fmax  = fmax + $urandom_range(0, 2) - 1;
            delta = (fmax > 64'hFFFF_FFFF) ? '1 : fmax[TIME_W-1:0];
        end else begin
            delta = $urandom_range(1, span[31:0]);
        end
    endtask

    // Defaults: zero delta, ticks, clamping, clear
    task automatic test_clear_and_zero();
        push_frame(MODE_ADVANCE, '0);
        push_frame(MODE_ADVANCE, 32'd33339);
        push_frame(MODE_ADVANCE, 32'hFFFF_FFFF);
        hold_off(3);
        push_frame(MODE_ADVANCE, '0);
        wait_drained();
        push_frame(MODE_CLEAR, 32'hFFFF_FFFF);
        push_frame(MODE_ADVANCE, '0);
        push_frame(MODE_ADVANCE, 32'd1);
        push_frame(MODE_CLEAR, '0);
        push_frame(MODE_ADVANCE, 32'd16667);
    endtask

    // Zero and masked register values, then the widest settings
    task automatic test_register_edges();
        set_timing(32'hFF00_0000, 32'd0, 32'hFFFF_FFC0);
        push_frame(MODE_ADVANCE, 32'd3);
        push_frame(MODE_ADVANCE, 32'd1);
        set_timing(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd63);
        push_frame(MODE_ADVANCE, 32'hFFFF_FFFF);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        push_frame(MODE_ADVANCE, 32'd5);
        push_frame(MODE_ADVANCE, 32'h0100_0000);
    endtask

    // Lower the step below a large leftover: alpha pegs at full scale
    task automatic test_alpha_saturation();
        set_timing(32'd1_000_000, 32'hFFFF_FFFF, 32'd5);
        push_frame(MODE_CLEAR, '0);
        push_frame(MODE_ADVANCE, 32'd999_999);
        set_timing(32'd1000, 32'hFFFF_FFFF, 32'd5);
        push_frame(MODE_ADVANCE, '0);
        push_frame(MODE_ADVANCE, 32'd1);
    endtask

    // Huge backlog on top of a clamped excess: dropped time saturates
    task automatic test_dropped_saturation();
        set_timing(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd1);
        push_frame(MODE_CLEAR, '0);
        push_frame(MODE_ADVANCE, 32'h00FF_FFFE);
        set_timing(32'd1, 32'd1, 32'd1);
        push_frame(MODE_ADVANCE, 32'hFFFF_FFFF);
    endtask

    // Random frames over several register settings, sent in bursts
    task automatic test_random_frames();
        logic              mode;
        logic [TIME_W-1:0] delta;
        int                burst;
        int                gap;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_timing(32'(STEP_RESET), 32'(FRAME_RESET), 32'(STEPS_RESET));
                1: set_timing($urandom_range(1, 64), $urandom_range(1, 4000), 32'd63);
                2: set_timing($urandom_range(1, 32'h00FF_FFFF), $urandom,
                              $urandom_range(1, 63));
                3: set_timing(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd1);
                4: set_timing(32'd1, 32'd1, 32'd63);
                default: set_timing($urandom, $urandom, $urandom);
            endcase
            burst = $urandom_range(1, 12);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick_frame(mode, delta);
                push_frame(mode, delta);
                burst--;
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end else if (burst == 0) begin
                    gap = $urandom_range(0, 7);
                    if (gap != 0)
                        hold_off(gap);
                    burst = $urandom_range(1, 12);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_clear_and_zero();
        test_register_edges();
        test_alpha_saturation();
        test_dropped_saturation();
        test_random_frames();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
